// ===== rtl/core/kct_pkg.sv =====
// kct_pkg: shared types, command codes and sizes for the keyed cell table
// no dependencies; imported by the interfaces, the cells, the resolver and the top level

package kct_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned CoordBits    = 8;
  localparam int unsigned ValueBits    = 16;
  localparam int unsigned CountBits    = 7;
  localparam int unsigned KeyBits      = 2 * CoordBits;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_UPDATE = 2'd3
  } kct_cmd_e;

  typedef logic [CoordBits-1:0]        kct_coord_t;
  typedef logic [KeyBits-1:0]          kct_key_t;   // {col, row}
  typedef logic signed [ValueBits-1:0] kct_val_t;
  typedef logic [CountBits-1:0]        kct_count_t;

  // four neighbor values, right / down / left / up
  typedef struct packed {
    kct_val_t right;
    kct_val_t down;
    kct_val_t left;
    kct_val_t up;
  } kct_quad_t;

  // contents of one cell, handed to the lower neighbor on a remove
  typedef struct packed {
    logic      valid;
    kct_key_t  key;
    kct_quad_t vals;
  } kct_entry_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic      cmp_en;  // latch key match this cycle
    logic      apply;   // commit the command this cycle
    kct_cmd_e  cmd;
    kct_key_t  key;
    kct_quad_t vals;
  } kct_ctrl_t;

endpackage

// ===== rtl/core/kct_if.sv =====
// kct_req_if / kct_rsp_if: valid/ready channels of the keyed cell table
// depends on kct_pkg

interface kct_req_if;
  logic                  valid;
  logic                  ready;
  kct_pkg::kct_cmd_e     command;
  kct_pkg::kct_coord_t   row;
  kct_pkg::kct_coord_t   col;
  kct_pkg::kct_val_t     right_value;
  kct_pkg::kct_val_t     down_value;
  kct_pkg::kct_val_t     left_value;
  kct_pkg::kct_val_t     up_value;

  modport source (
    output valid, command, row, col, right_value, down_value, left_value, up_value,
    input  ready
  );
  modport sink (
    input  valid, command, row, col, right_value, down_value, left_value, up_value,
    output ready
  );
endinterface

interface kct_rsp_if;
  logic                valid;
  logic                ready;
  logic                success;
  logic                table_full;
  kct_pkg::kct_val_t   right_out;
  kct_pkg::kct_val_t   down_out;
  kct_pkg::kct_val_t   left_out;
  kct_pkg::kct_val_t   up_out;
  kct_pkg::kct_count_t entry_count;

  modport source (
    output valid, success, table_full, right_out, down_out, left_out, up_out, entry_count,
    input  ready
  );
  modport sink (
    input  valid, success, table_full, right_out, down_out, left_out, up_out, entry_count,
    output ready
  );
endinterface

// ===== rtl/core/kct_cell.sv =====
// kct_cell: one slot of the table chain; holds valid, key and four neighbor values
// depends on kct_pkg; neighbors are the cells above and below in the chain

module kct_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kct_pkg::kct_ctrl_t  ctrl_i,
  input  logic                prev_valid_i,  // valid of the cell below
  input  kct_pkg::kct_entry_t next_i,        // contents of the cell above
  input  logic                first_i,       // this cell holds the oldest match
  input  logic                seen_i,        // at or above the oldest match
  output kct_pkg::kct_entry_t entry_o,
  output logic                hit_o,
  output kct_pkg::kct_quad_t  view_o
);
  import kct_pkg::*;

  logic      valid_q, valid_d;
  kct_key_t  key_q, key_d;
  kct_quad_t vals_q, vals_d;
  kct_quad_t sum;
  logic      hit_q;
  logic      free;

  // first empty slot: empty here, occupied below
  assign free = !valid_q && prev_valid_i;

  // wrapping adds for update
  assign sum.right = vals_q.right + ctrl_i.vals.right;
  assign sum.down  = vals_q.down  + ctrl_i.vals.down;
  assign sum.left  = vals_q.left  + ctrl_i.vals.left;
  assign sum.up    = vals_q.up    + ctrl_i.vals.up;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    vals_d  = vals_q;
    if (ctrl_i.apply) begin
      case (ctrl_i.cmd)
        CMD_ADD: begin
          if (free) begin
            valid_d = 1'b1;
            key_d   = ctrl_i.key;
            vals_d  = ctrl_i.vals;
          end
        end
        CMD_REMOVE: begin
          // compaction: take the upper neighbor's contents
          if (seen_i) begin
            valid_d = next_i.valid;
            key_d   = next_i.key;
            vals_d  = next_i.vals;
          end
        end
        CMD_UPDATE: begin
          if (first_i) begin
            vals_d = sum;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp_en) begin
        hit_q <= valid_q && (key_q == ctrl_i.key);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    vals_q <= vals_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.vals  = vals_q;
  assign hit_o         = hit_q;

  // values of the oldest match, with the update already added on update, zero elsewhere
  always_comb begin
    view_o = '0;
    if (first_i) begin
      view_o = (ctrl_i.cmd == CMD_UPDATE) ? sum : vals_q;
    end
  end

endmodule

// ===== rtl/core/kct_resolve.sv =====
// kct_resolve: picks the oldest match out of the registered per-cell hits
// depends on kct_pkg for the default depth

module kct_resolve #(
  parameter int unsigned TABLE_DEPTH = kct_pkg::DefaultDepth
) (
  input  logic [TABLE_DEPTH-1:0] hit_i,
  output logic [TABLE_DEPTH-1:0] first_o,
  output logic [TABLE_DEPTH-1:0] seen_o,
  output logic                   any_o
);
  import kct_pkg::*;

  logic [TABLE_DEPTH-1:0] upto;

  // ones up to and including the lowest hit; all ones when there is none
  assign upto    = hit_i ^ (hit_i - TABLE_DEPTH'(1));
  assign first_o = hit_i & upto;
  assign seen_o  = ~upto | first_o;
  assign any_o   = |hit_i;

endmodule

// ===== rtl/core/keyed_cell_table.sv =====
// keyed_cell_table: top level of the ordered table of grid cells keyed by row and column
// depends on kct_pkg, kct_req_if / kct_rsp_if, kct_cell and kct_resolve

// The table keeps up to TABLE_DEPTH entries, oldest first, in a chain of cells; each
// cell holds one key {col, row} and four signed neighbor values (right, down, left, up).
// In the transfer cycle of a request every cell compares its key against the request and
// registers a hit; in the commit state, once the output register is free, the oldest hit
// is picked by one subtract over the hit vector, the command is committed in all cells
// at once (append at the first empty cell, in-place add for update, or on remove every
// cell from the match up takes its upper neighbor's contents) and the result is loaded
// into the output register. Each request is taken only after the last is committed, and
// slower while the response side holds back a waiting result. Add does not check for
// duplicates and is refused with table_full when all cells are occupied; remove, lookup
// and update act on the oldest match and report success 0 with zero values on a miss.
// entry_count is the number of entries held after the operation, truncated to seven bits.

module keyed_cell_table #(
  parameter int unsigned TABLE_DEPTH = kct_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kct_req_if.sink   req_i,
  kct_rsp_if.source rsp_o
);
  import kct_pkg::*;

  localparam int unsigned CntBits = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e               state_q, state_d;
  kct_cmd_e             cmd_q;
  kct_key_t             key_q;
  kct_quad_t            vals_q;
  logic [CntBits-1:0]   count_q, count_d;

  logic                 req_xfer;
  logic                 exec_go;
  logic                 full;

  kct_ctrl_t            ctrl;
  kct_entry_t           entry [TABLE_DEPTH];
  kct_quad_t            view  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit, first, seen;
  logic                 any;
  kct_quad_t            sel;

  // result computed in the commit cycle
  logic                 res_success, res_full;
  kct_quad_t            res_vals;

  // output register
  logic                 rsp_valid_q;
  logic                 rsp_success_q, rsp_full_q;
  kct_quad_t            rsp_vals_q;
  kct_count_t           rsp_count_q;

  // ---------------------------------------------------------------- handshake
  // new request only when idle; commit waits for a free output register
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign exec_go     = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_xfer) state_d = ST_EXEC;
      ST_EXEC: if (exec_go)  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // request fields kept for the commit cycle
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      cmd_q       <= req_i.command;
      key_q       <= {req_i.col, req_i.row};
      vals_q.right <= req_i.right_value;
      vals_q.down  <= req_i.down_value;
      vals_q.left  <= req_i.left_value;
      vals_q.up    <= req_i.up_value;
    end
  end

  // ---------------------------------------------------------------- cell chain
  // compare uses the key on the request port, commit the registered one
  always_comb begin
    ctrl.cmp_en = req_xfer;
    ctrl.apply  = exec_go;
    ctrl.cmd    = cmd_q;
    ctrl.key    = (state_q == ST_IDLE) ? {req_i.col, req_i.row} : key_q;
    ctrl.vals   = vals_q;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic       prev_valid;
    kct_entry_t next_entry;

    // bottom cell always sees an occupied slot below, top cell an empty one above
    if (i == 0) begin : g_bottom
      assign prev_valid = 1'b1;
    end else begin : g_mid_lo
      assign prev_valid = entry[i-1].valid;
    end
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign next_entry = '0;
    end else begin : g_mid_hi
      assign next_entry = entry[i+1];
    end

    kct_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .next_i       (next_entry),
      .first_i      (first[i]),
      .seen_i       (seen[i]),
      .entry_o      (entry[i]),
      .hit_o        (hit[i]),
      .view_o       (view[i])
    );
  end

  kct_resolve #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_resolve (
    .hit_i   (hit),
    .first_o (first),
    .seen_o  (seen),
    .any_o   (any)
  );

  // views are zero except at the oldest match, so an or gathers the result
  always_comb begin
    sel = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel = sel | view[i];
    end
  end

  // ---------------------------------------------------------------- result and count
  assign full = (count_q == CntBits'(TABLE_DEPTH));

  always_comb begin
    res_success = 1'b0;
    res_full    = 1'b0;
    res_vals    = '0;
    count_d     = count_q;
    case (cmd_q)
      CMD_ADD: begin
        if (full) begin
          res_full = 1'b1;
        end else begin
          res_success = 1'b1;
          res_vals    = vals_q;
          count_d     = count_q + CntBits'(1);
        end
      end
      CMD_REMOVE: begin
        if (any) begin
          res_success = 1'b1;
          res_vals    = sel;
          count_d     = count_q - CntBits'(1);
        end
      end
      CMD_LOOKUP, CMD_UPDATE: begin
        if (any) begin
          res_success = 1'b1;
          res_vals    = sel;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      rsp_success_q <= res_success;
      rsp_full_q    <= res_full;
      rsp_vals_q    <= res_vals;
      rsp_count_q   <= CountBits'(count_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.success     = rsp_success_q;
  assign rsp_o.table_full  = rsp_full_q;
  assign rsp_o.right_out   = rsp_vals_q.right;
  assign rsp_o.down_out    = rsp_vals_q.down;
  assign rsp_o.left_out    = rsp_vals_q.left;
  assign rsp_o.up_out      = rsp_vals_q.up;
  assign rsp_o.entry_count = rsp_count_q;

endmodule

// ===== rtl/core/kct_checker.sv =====
// kct_checker: port-level checks on the keyed cell table, attached by bind
// depends on kct_pkg and the keyed_cell_table ports

module kct_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic                success_i,
  input logic                table_full_i,
  input kct_pkg::kct_val_t   right_i,
  input kct_pkg::kct_val_t   down_i,
  input kct_pkg::kct_val_t   left_i,
  input kct_pkg::kct_val_t   up_i,
  input kct_pkg::kct_count_t count_i
);
  import kct_pkg::*;

  // a held response keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({success_i, table_full_i, right_i, down_i, left_i, up_i, count_i}))
    else $error("response changed while stalled");

  // one request at a time: no transfer right after a transfer
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // every new response follows a request transfer
  a_rsp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i, 2))
    else $error("response without request");

  // misses and refusals carry zero values
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !success_i |-> right_i == '0 && down_i == '0 && left_i == '0 && up_i == '0)
    else $error("nonzero values on miss");

  // a refused add never reports success
  a_full_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && table_full_i |-> !success_i)
    else $error("table_full with success");

endmodule

bind keyed_cell_table kct_checker u_kct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .success_i    (rsp_o.success),
  .table_full_i (rsp_o.table_full),
  .right_i      (rsp_o.right_out),
  .down_i       (rsp_o.down_out),
  .left_i       (rsp_o.left_out),
  .up_i         (rsp_o.up_out),
  .count_i      (rsp_o.entry_count)
);
